>>> rtl/core/cdq_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// cdq_pkg
// Shared types and constants for the character deque: store geometry,
// request and status codes, controller/datapath command and status groups.
// ============================================================================
package cdq_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = IDX_W + 1;
    localparam int CHAR_W = 8;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [CHAR_W-1:0] char_t;

    typedef enum logic [2:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_REM_FRONT = 3'd2,
        REQ_REM_BACK  = 3'd3,
        REQ_TRAVERSE  = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic do_op;
        logic trav_start;
        logic trav_step;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic op_none;
        logic trav_go;
        logic trav_last;
    } stat_t;

endpackage

>>> rtl/core/cdq_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// cdq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is enabled.
// ============================================================================
module cdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/cdq_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// cdq_datapath
// Deque datapath: request capture, front index and count, ring store,
// traversal pointer, and the result output register.
// ============================================================================
module cdq_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cdq_pkg::cmd_t         cmd,
    output cdq_pkg::stat_t        stat,
    input  logic [7:0]            s_tdata,
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast,
    output logic [1:0]            m_tuser
);

    import cdq_pkg::*;

    function automatic idx_t idx_inc(input idx_t p);
        return (p == IDX_W'(DEPTH - 1)) ? '0 : p + IDX_W'(1);
    endfunction

    function automatic idx_t idx_dec(input idx_t p);
        return (p == '0) ? IDX_W'(DEPTH - 1) : p - IDX_W'(1);
    endfunction

    req_t    req_reg,       req_next;
    char_t   char_reg,      char_next;
    idx_t    front_reg,     front_next;
    cnt_t    count_reg,     count_next;
    idx_t    trav_ptr_reg,  trav_ptr_next;
    cnt_t    trav_left_reg, trav_left_next;
    logic    m_valid_reg,   m_valid_next;
    char_t   m_data_reg,    m_data_next;
    logic    m_last_reg,    m_last_next;
    status_t m_user_reg,    m_user_next;

    logic              ram_we;
    idx_t              ram_waddr;
    logic              ram_re;
    idx_t              ram_raddr;
    char_t             ram_rdata;
    logic [SUM_W-1:0]  back_sum;
    idx_t              back_pos;
    logic              is_full;
    logic              is_empty;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign back_sum = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign back_pos = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(back_sum);

    assign stat.out_free  = !m_valid_reg || m_tready;
    assign stat.op_none   = !(req_reg == REQ_INS_FRONT || req_reg == REQ_INS_BACK ||
                              req_reg == REQ_REM_FRONT || req_reg == REQ_REM_BACK ||
                              req_reg == REQ_TRAVERSE);
    assign stat.trav_go   = (req_reg == REQ_TRAVERSE) && !is_empty;
    assign stat.trav_last = (trav_left_reg == CNT_W'(1));

    always_comb begin
        req_next       = req_reg;
        char_next      = char_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        trav_ptr_next  = trav_ptr_reg;
        trav_left_next = trav_left_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        m_user_next    = m_user_reg;
        ram_we         = 1'b0;
        ram_waddr      = front_reg;
        ram_re         = 1'b0;
        ram_raddr      = front_reg;

        if (cmd.load) begin
            req_next  = req_t'(s_tuser);
            char_next = s_tdata;
        end

        if (cmd.do_op) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            m_last_next  = 1'b1;
            m_user_next  = ST_OK;
            unique case (req_reg)
                REQ_INS_FRONT, REQ_INS_BACK: begin
                    if (is_full) begin
                        m_user_next = ST_FULL;
                    end else begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        if (req_reg == REQ_INS_FRONT) begin
                            front_next = idx_dec(front_reg);
                            ram_waddr  = idx_dec(front_reg);
                        end else begin
                            ram_waddr  = back_pos;
                        end
                    end
                end
                REQ_REM_FRONT, REQ_REM_BACK: begin
                    if (is_empty) begin
                        m_user_next = ST_EMPTY;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(1)) begin
                            front_next = '0;
                        end else if (req_reg == REQ_REM_FRONT) begin
                            front_next = idx_inc(front_reg);
                        end
                    end
                end
                REQ_TRAVERSE: begin
                    m_user_next = ST_EMPTY;
                end
                default: begin
                    m_valid_next = m_valid_reg && !m_tready;
                end
            endcase
        end

        if (cmd.trav_start) begin
            ram_re         = 1'b1;
            ram_raddr      = front_reg;
            trav_ptr_next  = idx_inc(front_reg);
            trav_left_next = count_reg;
        end

        if (cmd.trav_step) begin
            m_valid_next   = 1'b1;
            m_data_next    = ram_rdata;
            m_last_next    = (trav_left_reg == CNT_W'(1));
            m_user_next    = ST_OK;
            ram_re         = 1'b1;
            ram_raddr      = trav_ptr_reg;
            trav_ptr_next  = idx_inc(trav_ptr_reg);
            trav_left_next = trav_left_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            count_reg     <= '0;
            trav_left_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            trav_left_reg <= trav_left_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        char_reg     <= char_next;
        trav_ptr_reg <= trav_ptr_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
        m_user_reg   <= m_user_next;
    end

    cdq_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (char_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

>>> rtl/core/cdq_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// cdq_ctrl
// Deque controller: accepts one request, runs it, and steps a traversal
// one element per cycle while the output register can take it.
// ============================================================================
module cdq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  cdq_pkg::stat_t stat,
    output cdq_pkg::cmd_t  cmd
);

    import cdq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_TRAV = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                priority if (stat.op_none) begin
                    state_next = S_IDLE;
                end else if (stat.trav_go) begin
                    cmd.trav_start = 1'b1;
                    state_next     = S_TRAV;
                end else if (stat.out_free) begin
                    cmd.do_op  = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_EXEC;
                end
            end
            S_TRAV: begin
                if (stat.out_free) begin
                    cmd.trav_step = 1'b1;
                    if (stat.trav_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/char_deque_with_traversal_unit.sv
`timescale 1ns / 1ps
// Insert and remove: the request is captured on accept and its result is registered from EXEC.
// Traverse of N elements: a first read of the ring store, then one result per cycle
//   while the output register can take it, front to back.
// Output stalls hold the controller; a new item is taken once the result is loaded.
// Reset (aresetn low, synchronous) empties the deque and clears the front index;
//   store contents are left as they are and need no clearing pass.
// ============================================================================
// char_deque_with_traversal_unit
// Bounded double-ended queue of characters in a ring store, with insert and
// remove at both ends and a front-to-back traversal.
// ============================================================================
module char_deque_with_traversal_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] new_char
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] char_out
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // [1:0] status
);

    import cdq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    cdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cdq_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

>>> rtl/core/cdq_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// cdq_checker
// Port-level checks for the character deque, bound to the top level.
// ============================================================================
module cdq_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    import cdq_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tlast) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_status_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tlast && m_tdata == '0)
        else $error("status result not a lone zero-data item");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == ST_OK || m_tuser == ST_EMPTY || m_tuser == ST_FULL)
        else $error("undefined status code");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous item still in progress");

endmodule

bind char_deque_with_traversal_unit cdq_checker u_cdq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for char_deque_with_traversal_unit. A short directed
// table covers the empty, sole-element and reserved-code cases. Weighted
// random requests then grow the deque past full and drain it again. Every
// result is checked, against the directed table's expected entry or against a
// deque kept inside the bench, and both stream sides stall at random.
// ============================================================================
module tb;
    import cdq_pkg::*;

    localparam logic [2:0] REQ_RSVD_LO  = 3'd5;
    localparam logic [2:0] REQ_RSVD_MID = 3'd6;
    localparam logic [2:0] REQ_RSVD_HI  = 3'd7;
    localparam int RANDOM_ITEMS = 230;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = DEPTH + 16;
    localparam int MAX_REPORTS  = 10;
    localparam int IDLE_PCT     = 26;

    typedef struct packed {
        char_t   ch;
        logic    last;
        status_t st;
    } result_t;

    typedef struct packed {
        logic [2:0] code;
        char_t      ch;
        logic       typed;
        result_t    want;
    } stim_row_t;

    typedef enum {MODE_MIX, MODE_GROW, MODE_DRAIN} mix_mode_t;

    localparam result_t RES_OK    = '{8'h00, 1'b1, ST_OK};
    localparam result_t RES_EMPTY = '{8'h00, 1'b1, ST_EMPTY};

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic [2:0] s_tuser  = REQ_INS_FRONT;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;

    logic    item_typed = 1'b0;
    result_t item_want  = '0;
    bit      calm       = 1'b0;
    int      errors     = 0;
    int      stall_cycles = 0;

    char_t   deque_store [DEPTH];
    idx_t    deque_front = '0;
    cnt_t    deque_count = '0;
    result_t expected_results [$];

    stim_row_t directed_rows [23] = '{
        '{REQ_REM_FRONT, 8'h00, 1'b1, RES_EMPTY},
        '{REQ_REM_BACK,  8'hFF, 1'b1, RES_EMPTY},
        '{REQ_TRAVERSE,  8'h00, 1'b1, RES_EMPTY},
        '{REQ_RSVD_LO,   8'h11, 1'b0, '0},
        '{REQ_INS_FRONT, 8'h00, 1'b1, RES_OK},
        '{REQ_INS_BACK,  8'hFF, 1'b1, RES_OK},
        '{REQ_INS_FRONT, 8'h80, 1'b0, '0},
        '{REQ_INS_BACK,  8'h01, 1'b0, '0},
        '{REQ_TRAVERSE,  8'h00, 1'b0, '0},
        '{REQ_RSVD_MID,  8'h22, 1'b0, '0},
        '{REQ_REM_FRONT, 8'h5A, 1'b1, RES_OK},
        '{REQ_REM_BACK,  8'hA5, 1'b1, RES_OK},
        '{REQ_TRAVERSE,  8'h00, 1'b0, '0},
        '{REQ_REM_BACK,  8'h00, 1'b1, RES_OK},
        '{REQ_TRAVERSE,  8'h00, 1'b0, '0},
        '{REQ_REM_FRONT, 8'h00, 1'b1, RES_OK},
        '{REQ_TRAVERSE,  8'hFF, 1'b1, RES_EMPTY},
        '{REQ_REM_BACK,  8'h00, 1'b1, RES_EMPTY},
        '{REQ_INS_BACK,  8'h7F, 1'b1, RES_OK},
        '{REQ_RSVD_HI,   8'hAA, 1'b0, '0},
        '{REQ_REM_BACK,  8'h00, 1'b1, RES_OK},
        '{REQ_INS_FRONT, 8'hC3, 1'b0, '0},
        '{REQ_TRAVERSE,  8'h00, 1'b0, '0}
    };

    char_deque_with_traversal_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic void log_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // Advance the deque by one request; queue its results when keep is set.
    function automatic void deque_apply(input logic [2:0] code, input char_t ch,
                                        input logic keep);
        result_t res [$];
        int      pos;
        case (code)
            REQ_INS_FRONT, REQ_INS_BACK: begin
                if (int'(deque_count) >= DEPTH) begin
                    res.push_back('{8'h00, 1'b1, ST_FULL});
                end else begin
                    if (code == REQ_INS_FRONT) begin
                        deque_front = idx_t'((int'(deque_front) + DEPTH - 1) % DEPTH);
                        deque_store[deque_front] = ch;
                    end else begin
                        pos = (int'(deque_front) + int'(deque_count)) % DEPTH;
                        deque_store[pos] = ch;
                    end
                    deque_count++;
                    res.push_back(RES_OK);
                end
            end
            REQ_REM_FRONT, REQ_REM_BACK: begin
                if (deque_count == 0) begin
                    res.push_back(RES_EMPTY);
                end else begin
                    if (code == REQ_REM_FRONT)
                        deque_front = idx_t'((int'(deque_front) + 1) % DEPTH);
                    deque_count--;
                    if (deque_count == 0) deque_front = '0;
                    res.push_back(RES_OK);
                end
            end
            REQ_TRAVERSE: begin
                if (deque_count == 0) begin
                    res.push_back(RES_EMPTY);
                end else begin
                    for (int i = 0; i < int'(deque_count); i++) begin
                        pos = (int'(deque_front) + i) % DEPTH;
                        res.push_back('{deque_store[pos], i == int'(deque_count) - 1, ST_OK});
                    end
                end
            end
            default: ;
        endcase
        if (keep) foreach (res[k]) expected_results.push_back(res[k]);
    endfunction

    function automatic logic [2:0] pick_request(input mix_mode_t mode);
        int roll;
        int ins_pct;
        int rem_pct;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_GROW: begin
                ins_pct = 85;
                rem_pct = 5;
            end
            MODE_DRAIN: begin
                ins_pct = 5;
                rem_pct = 85;
            end
            default: begin
                ins_pct = 40;
                rem_pct = 40;
            end
        endcase
        if (roll < ins_pct) return $urandom_range(0, 1) ? REQ_INS_BACK : REQ_INS_FRONT;
        if (roll < ins_pct + rem_pct)
            return $urandom_range(0, 1) ? REQ_REM_BACK : REQ_REM_FRONT;
        if (roll < 96) return REQ_TRAVERSE;
        return 3'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));
    endfunction

    task automatic send_request(input logic [2:0] code, input char_t ch,
                                input logic typed, input result_t want);
        @(negedge aclk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= code;
        s_tdata    <= ch;
        item_typed <= typed;
        item_want  <= want;
        do @(posedge aclk); while (!s_tready);
    endtask

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    log_error($sformatf("unexpected result: char %h last %b status %0d",
                                        m_tdata, m_tlast, m_tuser));
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.ch || m_tlast !== want.last || m_tuser !== want.st)
                        log_error($sformatf({"expected char %h last %b status %0d, ",
                                             "got char %h last %b status %0d"},
                                            want.ch, want.last, want.st,
                                            m_tdata, m_tlast, m_tuser));
                end
            end
            if (s_tvalid && s_tready) begin
                deque_apply(s_tuser, s_tdata, !item_typed);
                if (item_typed) expected_results.push_back(item_want);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        mix_mode_t mode;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[r])
            send_request(directed_rows[r].code, directed_rows[r].ch,
                         directed_rows[r].typed, directed_rows[r].want);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 60 && n < 130);
            mode = (n < 50) ? MODE_MIX : ((n < 150) ? MODE_GROW : MODE_DRAIN);
            send_request(pick_request(mode), char_t'($urandom_range(0, 255)), 1'b0, '0);
        end
        calm = 1'b0;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
